// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define BBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define BBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/bba_pkg.sv =====
// Shared types and constants of the bitmap block allocator.
// No dependencies; used by the interfaces and all allocator modules.
package bba_pkg;

    // Field widths of the item channels
    localparam int MODE_W    = 1;
    localparam int LEN_W     = 7;
    localparam int ADDR_W    = 32;
    localparam int USED_W    = 11;

    // Bitmap word geometry
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;
    localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hffffffff;

    // Default sizing
    localparam int DEF_NUM_BLOCKS  = 1024;
    localparam int DEF_BLOCK_BYTES = 4096;
    localparam int DEF_MAX_RUN     = 64;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_SCAN_RD,
        ST_SCAN,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_MUL,
        ST_DONE
    } bba_state_t;

    // Outcome of scanning one bitmap word
    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] hit_bit;
        logic [LEN_W-1:0] run_out;
    } bba_scan_res_t;

    // Result item payload
    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] block_address;
        logic [USED_W-1:0] used_blocks;
    } bba_rsp_t;

endpackage

// ===== rtl/core/bba_req_if.sv =====
// Request channel of the allocator: valid/ready plus request fields.
// Depends on bba_pkg for the field widths.
interface bba_req_if;
    import bba_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0]  run_length;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output mode, output run_length, output address,
                    input ready);
    modport sink   (input valid, input mode, input run_length, input address,
                    output ready);
endinterface

// ===== rtl/core/bba_rsp_if.sv =====
// Response channel of the allocator: valid/ready plus result fields.
// Depends on bba_pkg for the field widths.
interface bba_rsp_if;
    import bba_pkg::*;

    logic              valid;
    logic              ready;
    logic              ok;
    logic [ADDR_W-1:0] block_address;
    logic [USED_W-1:0] used_blocks;

    modport source (output valid, output ok, output block_address, output used_blocks,
                    input ready);
    modport sink   (input valid, input ok, input block_address, input used_blocks,
                    output ready);
endinterface

// ===== rtl/core/bba_bitmap_mem.sv =====
// Occupancy bitmap storage: one write port, one registered read port.
// Depends on bba_pkg for the word width.
module bba_bitmap_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic [bba_pkg::WORD_BITS-1:0] wdata,
    input  logic [AW-1:0]                 raddr,
    output logic [bba_pkg::WORD_BITS-1:0] rdata
);
    import bba_pkg::*;

    logic [WORD_BITS-1:0] mem_reg [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    // Write one word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read one word, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/core/bba_word_scan.sv =====
// First-fit run detector for one 32-bit bitmap word with a carried-in run.
// Depends on bba_pkg for widths and the scan result type.
module bba_word_scan (
    input  logic [bba_pkg::WORD_BITS-1:0] word,
    input  logic [bba_pkg::LEN_W-1:0]     run_in,
    input  logic [bba_pkg::LEN_W-1:0]     len,
    output bba_pkg::bba_scan_res_t        res
);
    import bba_pkg::*;

    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS:0]   free_inc;
    logic [WORD_BITS-1:0] prefix_free;
    logic [WORD_BITS-1:0] window;
    logic [WORD_BITS-1:0] thresh;
    logic [WORD_BITS-1:0] hits;
    logic [LEN_W:0]       need;
    logic [BIT_W-1:0]     first_hit;
    logic [BIT_W:0]       top_free;

    assign free_bits = ~word;

    // Mark bits that have every bit from 0 up to them free
    assign free_inc    = {1'b0, free_bits} + (WORD_BITS+1)'(1);
    assign prefix_free = WORD_BITS'((({1'b0, free_bits} ^ free_inc) >> 1));

    // Mark bits that end a free window of len bits inside this word
    always_comb
    begin
        window = FULL_WORD;
        for (int k = 0; k < WORD_BITS; k++)
        begin
            if (k < int'(len))
            begin
                window = window & (free_bits << k);
            end
        end
        if (int'(len) > WORD_BITS)
        begin
            window = '0;
        end
    end

    // Mark bits where the carried run plus the free prefix reaches len
    assign need = {1'b0, len} - {1'b0, run_in};
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            thresh[b] = ((LEN_W+1)'(b) + (LEN_W+1)'(1)) >= need;
        end
    end

    assign hits = window | (prefix_free & thresh);

    // Pick the lowest bit that completes a run
    always_comb
    begin
        first_hit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (hits[b])
            begin
                first_hit = BIT_W'(b);
            end
        end
    end

    // Count free bits at the top of the word to carry into the next one
    always_comb
    begin
        top_free = (BIT_W+1)'(WORD_BITS);
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (word[b])
            begin
                top_free = (BIT_W+1)'(WORD_BITS - 1 - b);
            end
        end
    end

    always_comb
    begin
        res.hit     = |hits;
        res.hit_bit = first_hit;
        if (&free_bits)
        begin
            res.run_out = run_in + LEN_W'(WORD_BITS);
        end
        else
        begin
            res.run_out = LEN_W'(top_free);
        end
    end
endmodule

// ===== rtl/core/bba_frame_div.sv =====
// Frame index of an address offset: a registered right shift by log2 of the block size.
// Depends on bba_pkg for the address width.
module bba_frame_div #(
    parameter int DIVISOR = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bba_pkg::ADDR_W-1:0] dividend,
    output logic                       done,
    output logic [bba_pkg::ADDR_W-1:0] quotient
);
    import bba_pkg::*;

    // Block size is a power of two, so the quotient is a shift
    localparam int SHIFT = $clog2(DIVISOR);

    logic              done_reg;
    logic [ADDR_W-1:0] q_reg;

    // Flag the quotient in the cycle after start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    // Capture the shifted offset
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend >> SHIFT;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

// ===== rtl/core/bitmap_block_allocator.sv =====
// Top level of the bitmap first-fit block allocator: sequencer and datapath.
// Depends on bba_pkg, bba_req_if, bba_rsp_if, bba_bitmap_mem, bba_word_scan,
// bba_frame_div and assert_macros.svh.
//
//  Channel | Dir | Handshake        | Payload
//  --------+-----+------------------+------------------------------------------
//  req     | in  | valid / ready    | mode, run_length, address
//  rsp     | out | valid / ready    | ok, block_address, used_blocks
//  cfg     | in  | cfg_we (no wait) | cfg_wdata -> base_address
//
// One item at a time; the bitmap memory and the word scanner set the pace. Allocate:
// accept, read the first word, scan words in turn (up to NUM_BLOCKS/32), read and write
// each word marked, multiply, load the result. Free: accept, shift for the frame index
// (BLOCK_BYTES a power of two), read and write each word cleared, load. Bad length or full
// heap go straight to the load; a free out of range shifts first. After reset a clearing
// pass writes NUM_BLOCKS/32 words, one per cycle, with ready low. A result that waits in
// the output register holds the next one in its load state; the next item may still enter.
`include "assert_macros.svh"

module bitmap_block_allocator #(
    parameter int NUM_BLOCKS  = bba_pkg::DEF_NUM_BLOCKS,
    parameter int BLOCK_BYTES = bba_pkg::DEF_BLOCK_BYTES,
    parameter int MAX_RUN     = bba_pkg::DEF_MAX_RUN
) (
    input  logic                       clk,
    input  logic                       rst_n,
    bba_req_if.sink                    req,
    bba_rsp_if.source                  rsp,
    input  logic                       cfg_we,
    input  logic [bba_pkg::ADDR_W-1:0] cfg_wdata
);
    import bba_pkg::*;

    localparam int WORD_COUNT   = NUM_BLOCKS / WORD_BITS;
    localparam int TOTAL_BLOCKS = WORD_COUNT * WORD_BITS;
    localparam int WORD_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BIDX_W       = WORD_W + BIT_W;
    localparam int CNT_W        = $clog2(TOTAL_BLOCKS + 1);
    localparam int UPD_W        = CNT_W + LEN_W;
    localparam logic [CNT_W-1:0]  TOTAL_CNT = CNT_W'(TOTAL_BLOCKS);
    localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(WORD_COUNT - 1);

    bba_state_t state_reg, state_next;

    logic [WORD_W-1:0] clr_addr_reg;
    logic [CNT_W-1:0]  used_count_reg;
    logic [ADDR_W-1:0] base_reg;
    logic              out_valid_reg;
    bba_rsp_t          rsp_reg;

    logic [MODE_W-1:0] mode_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [WORD_W-1:0] scan_word_reg;
    logic [LEN_W-1:0]  run_reg;
    logic [BIDX_W-1:0] start_reg;
    logic [WORD_W-1:0] mark_word_reg;
    logic              ok_reg;
    logic [ADDR_W-1:0] prod_reg;

    logic                 accept;
    logic                 len_ok;
    logic                 used_full;
    logic                 out_free;
    logic                 mem_we;
    logic [WORD_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_W-1:0]    mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;
    bba_scan_res_t        scan_res;
    logic                 div_start;
    logic                 div_done;
    logic [ADDR_W-1:0]    div_q;
    logic                 frame_ok;
    logic [BIDX_W-1:0]    scan_start;
    logic [BIDX_W-1:0]    end_idx;
    logic [BIT_W-1:0]     lo_bit;
    logic [BIT_W-1:0]     hi_bit;
    logic [WORD_BITS-1:0] run_mask;
    logic [WORD_BITS-1:0] marked_word;
    logic [UPD_W-1:0]     used_ext;
    logic [UPD_W-1:0]     len_ext;
    logic [CNT_W-1:0]     used_after;
    logic                 last_mark;

    // Storage and shared units
    bba_bitmap_mem #(
        .DEPTH (WORD_COUNT),
        .AW    (WORD_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bba_word_scan u_scan (
        .word   (mem_rdata),
        .run_in (run_reg),
        .len    (len_reg),
        .res    (scan_res)
    );

    bba_frame_div #(
        .DIVISOR (BLOCK_BYTES)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (req.address - base_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Request checks
    assign accept    = req.valid && req.ready;
    assign len_ok    = (req.run_length != '0) && (32'(req.run_length) <= 32'(MAX_RUN));
    assign used_full = used_count_reg >= TOTAL_CNT;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign frame_ok  = ({1'b0, div_q} + (ADDR_W+1)'(len_reg)) <= (ADDR_W+1)'(TOTAL_BLOCKS);

    // Run start when the scanner finds the end of a run
    assign scan_start = BIDX_W'({scan_word_reg, scan_res.hit_bit}) + BIDX_W'(1)
                        - BIDX_W'(len_reg);

    // Build the bit mask of the run inside the current word
    assign end_idx   = start_reg + BIDX_W'(len_reg) - BIDX_W'(1);
    assign lo_bit    = (mark_word_reg == start_reg[BIDX_W-1:BIT_W]) ?
                       start_reg[BIT_W-1:0] : '0;
    assign hi_bit    = (mark_word_reg == end_idx[BIDX_W-1:BIT_W]) ?
                       end_idx[BIT_W-1:0] : BIT_W'(WORD_BITS - 1);
    assign run_mask  = (FULL_WORD << lo_bit) & (FULL_WORD >> (BIT_W'(WORD_BITS - 1) - hi_bit));
    assign marked_word = (mode_reg == MODE_FREE) ? (mem_rdata & ~run_mask)
                                                 : (mem_rdata | run_mask);
    assign last_mark = mark_word_reg == end_idx[BIDX_W-1:BIT_W];

    // Count update: add on allocate, saturating subtract on free
    assign used_ext = UPD_W'(used_count_reg);
    assign len_ext  = UPD_W'(len_reg);
    always_comb
    begin
        if (mode_reg == MODE_FREE)
        begin
            used_after = (used_ext > len_ext) ? CNT_W'(used_ext - len_ext) : '0;
        end
        else
        begin
            used_after = CNT_W'(used_ext + len_ext);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (!len_ok)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (req.mode == MODE_FREE)
                    begin
                        state_next = ST_DIV;
                    end
                    else if (used_full)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = frame_ok ? ST_MARK_RD : ST_DONE;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                priority if (scan_res.hit)
                begin
                    state_next = ST_MARK_RD;
                end
                else if (scan_word_reg == LAST_WORD)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MARK_RD:
            begin
                state_next = ST_MARK_WR;
            end
            ST_MARK_WR:
            begin
                if (last_mark)
                begin
                    state_next = (mode_reg == MODE_ALLOC) ? ST_MUL : ST_DONE;
                end
                else
                begin
                    state_next = ST_MARK_RD;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control outputs per state
    always_comb
    begin
        req.ready = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = mark_word_reg;
        mem_wdata = marked_word;
        mem_raddr = mark_word_reg;
        div_start = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
                div_start = req.valid && len_ok && (req.mode == MODE_FREE);
            end
            ST_SCAN_RD:
            begin
                mem_raddr = '0;
            end
            ST_SCAN:
            begin
                mem_raddr = scan_word_reg + WORD_W'(1);
            end
            ST_MARK_WR:
            begin
                mem_we = 1'b1;
            end
            ST_DIV, ST_MARK_RD, ST_MUL, ST_DONE:
            begin
                mem_raddr = mark_word_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Control state: sequencer, clearing sweep, count, base, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            used_count_reg <= '0;
            base_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + WORD_W'(1);
            end
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            if (state_reg == ST_MARK_WR && last_mark)
            begin
                used_count_reg <= used_after;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_reg      <= req.mode;
                    len_reg       <= req.run_length;
                    ok_reg        <= 1'b0;
                    scan_word_reg <= '0;
                    run_reg       <= '0;
                end
            end
            ST_DIV:
            begin
                start_reg     <= BIDX_W'(div_q);
                mark_word_reg <= div_q[BIDX_W-1:BIT_W];
            end
            ST_SCAN:
            begin
                if (scan_res.hit)
                begin
                    start_reg     <= scan_start;
                    mark_word_reg <= scan_start[BIDX_W-1:BIT_W];
                end
                else
                begin
                    run_reg       <= scan_res.run_out;
                    scan_word_reg <= scan_word_reg + WORD_W'(1);
                end
            end
            ST_MARK_WR:
            begin
                mark_word_reg <= mark_word_reg + WORD_W'(1);
                if (last_mark)
                begin
                    ok_reg <= 1'b1;
                end
            end
            ST_MUL:
            begin
                prod_reg <= ADDR_W'(start_reg) * ADDR_W'(BLOCK_BYTES);
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_reg.ok            <= ok_reg;
                    rsp_reg.block_address <= (ok_reg && mode_reg == MODE_ALLOC) ?
                                             (base_reg + prod_reg) : '0;
                    rsp_reg.used_blocks   <= USED_W'(used_count_reg);
                end
            end
            ST_CLEAR, ST_SCAN_RD, ST_MARK_RD:
            begin
                run_reg <= run_reg;
            end
            default:
            begin
                run_reg <= run_reg;
            end
        endcase
    end

    // Drive the result channel
    assign rsp.valid         = out_valid_reg;
    assign rsp.ok            = rsp_reg.ok;
    assign rsp.block_address = rsp_reg.block_address;
    assign rsp.used_blocks   = rsp_reg.used_blocks;

    // Checks
    `BBA_ASSERT_IMP(a_used_bound, clk, rst_n, 1'b1, used_count_reg <= TOTAL_CNT)
    `BBA_ASSERT_IMP(a_valid_from_done, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == ST_DONE)
    `BBA_ASSERT_IMP(a_fail_zero_addr, clk, rst_n, rsp.valid && !rsp.ok, rsp.block_address == '0)
    `BBA_ASSERT_NXT(a_done_delivers, clk, rst_n, state_reg == ST_DONE && out_free, out_valid_reg && state_reg == ST_IDLE)
endmodule
